FILE: hdl/usc_pkg.sv
// ----------------------------------------------------------------------------
// usc_pkg: shared types and walk logic for the serial device classifier
// Beat payloads, the descriptor walk state and the per-byte walk function.
// ----------------------------------------------------------------------------
package usc_pkg;

	localparam logic [7:0] DESC_TYPE_INTERFACE = 8'h04;
	localparam logic [7:0] IFACE_MIN_LENGTH    = 8'd9;
	localparam logic [7:0] CLASS_CDC           = 8'h02;
	localparam logic [7:0] SUBCLASS_ACM        = 8'h02;
	localparam logic [7:0] CLASS_CDC_DATA      = 8'h0a;
	localparam logic [7:0] OFFSET_TYPE         = 8'd1;
	localparam logic [7:0] OFFSET_CLASS        = 8'd5;
	localparam logic [7:0] OFFSET_SUBCLASS     = 8'd6;
	localparam logic [7:0] MIN_DESC_LENGTH     = 8'd2;

	localparam logic [15:0] VID_A    = 16'h2341;
	localparam logic [15:0] VID_B    = 16'h2a03;
	localparam logic [15:0] VID_C    = 16'h1a86;
	localparam logic [15:0] PID_C0   = 16'h7523;
	localparam logic [15:0] PID_C1   = 16'h5523;
	localparam logic [15:0] PID_C2   = 16'h55d4;
	localparam logic [15:0] VID_D    = 16'h10c4;
	localparam logic [15:0] PID_D    = 16'hea60;
	localparam logic [15:0] VID_E    = 16'h0403;
	localparam logic [15:0] PID_E    = 16'h6001;

	localparam logic [15:0] POS_MAX  = 16'hffff;
	localparam logic [15:0] HDR_LAST = 16'd3;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        last;
		logic [7:0]  device_class;
		logic [15:0] vendor_id;
		logic [15:0] product_id;
	} usc_item_t;

	typedef struct packed {
		logic is_serial_device;
		logic cdc_control_found;
		logic cdc_data_found;
		logic known_id_match;
		logic walk_stopped_early;
	} usc_result_t;

	typedef struct packed {
		logic [15:0] total_length;
		logic [7:0]  bytes_left;
		logic [7:0]  current_length;
		logic [7:0]  current_type;
		logic [7:0]  interface_class;
		logic        control_seen;
		logic        data_seen;
		logic        walk_stopped;
	} usc_walk_t;

	// Advance the descriptor walk by one byte at position pos.
	function automatic usc_walk_t walk_byte(usc_walk_t s, logic [15:0] pos, logic [7:0] b);
		usc_walk_t  r;
		logic [7:0] offset;
		logic       iface;
		r      = s;
		offset = s.current_length - s.bytes_left;
		iface  = (s.current_type == DESC_TYPE_INTERFACE) &&
			(s.current_length >= IFACE_MIN_LENGTH);
		if (!s.walk_stopped && (pos < s.total_length)) begin
			if (s.bytes_left == 8'd0) begin
				// a descriptor start with under two bytes to go ends the walk quietly
				if (({1'b0, pos} + 17'd2) <= {1'b0, s.total_length}) begin
					if ((b < MIN_DESC_LENGTH) ||
						(({1'b0, pos} + {9'd0, b}) > {1'b0, s.total_length})) begin
						r.walk_stopped = 1'b1;
					end else begin
						r.current_length  = b;
						r.bytes_left      = b - 8'd1;
						r.current_type    = 8'd0;
						r.interface_class = 8'd0;
					end
				end
			end else begin
				r.bytes_left = s.bytes_left - 8'd1;
				if (offset == OFFSET_TYPE) begin
					r.current_type = b;
				end else if (offset == OFFSET_CLASS) begin
					r.interface_class = b;
					if (iface && (b == CLASS_CDC_DATA)) begin
						r.data_seen = 1'b1;
					end
				end else if (offset == OFFSET_SUBCLASS) begin
					if (iface && (s.interface_class == CLASS_CDC) && (b == SUBCLASS_ACM)) begin
						r.control_seen = 1'b1;
					end
				end
			end
		end
		return r;
	endfunction

	function automatic logic known_pair(logic [15:0] vid, logic [15:0] pid);
		logic hit;
		hit = (vid == VID_A) || (vid == VID_B) ||
			((vid == VID_C) && ((pid == PID_C0) || (pid == PID_C1) || (pid == PID_C2))) ||
			((vid == VID_D) && (pid == PID_D)) ||
			((vid == VID_E) && (pid == PID_E));
		return hit;
	endfunction

endpackage

FILE: hdl/usc_walk.sv
// ----------------------------------------------------------------------------
// usc_walk: next walk state for one descriptor byte
// Handles the buffered four-byte header, walked at once when the total is known.
// ----------------------------------------------------------------------------
module usc_walk (
	input  usc_pkg::usc_walk_t  cur,
	input  logic [15:0]         pos,
	input  logic [7:0]          data_byte,
	input  logic                last,
	input  logic [2:0][7:0]     hdr,
	output usc_pkg::usc_walk_t  nxt
);

	logic [1:0]         pos_lo;
	logic [3:0][7:0]    hv;
	logic [7:0]         tot_lo;
	logic [7:0]         tot_hi;
	usc_pkg::usc_walk_t w0;
	usc_pkg::usc_walk_t w1;
	usc_pkg::usc_walk_t w2;
	usc_pkg::usc_walk_t w3;
	usc_pkg::usc_walk_t w4;

	assign pos_lo = pos[1:0];

	// header bytes as they stand once this beat is stored
	always_comb begin
		hv[0]  = (pos_lo == 2'd0) ? data_byte : hdr[0];
		hv[1]  = (pos_lo == 2'd1) ? data_byte : hdr[1];
		hv[2]  = (pos_lo == 2'd2) ? data_byte : hdr[2];
		hv[3]  = data_byte;
		tot_lo = (pos_lo == 2'd2) ? data_byte : ((pos_lo == 2'd3) ? hdr[2] : 8'd0);
		tot_hi = (pos_lo == 2'd3) ? data_byte : 8'd0;
	end

	always_comb begin
		w0              = cur;
		w0.total_length = {tot_hi, tot_lo};
		w1 = usc_pkg::walk_byte(w0, 16'd0, hv[0]);
		w2 = (pos_lo >= 2'd1) ? usc_pkg::walk_byte(w1, 16'd1, hv[1]) : w1;
		w3 = (pos_lo >= 2'd2) ? usc_pkg::walk_byte(w2, 16'd2, hv[2]) : w2;
		w4 = (pos_lo == 2'd3) ? usc_pkg::walk_byte(w3, 16'd3, hv[3]) : w3;
		if (pos <= usc_pkg::HDR_LAST) begin
			nxt = ((pos == usc_pkg::HDR_LAST) || last) ? w4 : cur;
		end else begin
			nxt = usc_pkg::walk_byte(cur, pos, data_byte);
		end
	end

endmodule

FILE: hdl/usb_serial_device_classifier_core.sv
// ----------------------------------------------------------------------------
// usb_serial_device_classifier_core: CDC serial device detector
// Walks a configuration descriptor set byte by byte and reports a verdict
// on the beat marked last.
// ----------------------------------------------------------------------------
//  channel  | valid         | stall         | payload
//  ---------+---------------+---------------+----------------------
//  input    | item_valid    | item_stall    | item   (usc_item_t)
//  output   | result_valid  | result_stall  | result (usc_result_t)
//
// One beat per cycle sustained while not stalled; a result is registered as its
// last beat leaves. The walk state updates in one pass from the input register.
// Reset clears the walk state and both valid flags; no clearing pass.
// Input stalls only while a last beat waits on a full, stalled result register.
// ----------------------------------------------------------------------------
module usb_serial_device_classifier_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  usc_pkg::usc_item_t   item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output usc_pkg::usc_result_t result
);

	usc_pkg::usc_item_t   item_s1;
	logic                 valid_s1;
	usc_pkg::usc_walk_t   walk_q;
	usc_pkg::usc_walk_t   walk_next;
	logic [15:0]          byte_position_q;
	logic [2:0][7:0]      hdr_q;
	usc_pkg::usc_result_t result_q;
	logic                 result_valid_q;
	logic                 out_free;
	logic                 go_s1;
	logic                 take;
	logic                 known;

	assign out_free   = !result_valid_q || !result_stall;
	assign go_s1      = valid_s1 && (!item_s1.last || out_free);
	assign item_stall = valid_s1 && !go_s1;
	assign take       = item_valid && !item_stall;

	usc_walk u_walk (
		.cur       (walk_q),
		.pos       (byte_position_q),
		.data_byte (item_s1.data_byte),
		.last      (item_s1.last),
		.hdr       (hdr_q),
		.nxt       (walk_next)
	);

	assign known = usc_pkg::known_pair(item_s1.vendor_id, item_s1.product_id);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q          <= '0;
			byte_position_q <= '0;
		end else if (go_s1) begin
			if (item_s1.last) begin
				walk_q          <= '0;
				byte_position_q <= '0;
			end else begin
				walk_q <= walk_next;
				if (byte_position_q != usc_pkg::POS_MAX) begin
					byte_position_q <= byte_position_q + 16'd1;
				end
			end
		end
	end

	// hold the first header bytes until the total length is known
	always_ff @(posedge clk) begin
		if (go_s1 && (byte_position_q < usc_pkg::HDR_LAST)) begin
			hdr_q[byte_position_q[1:0]] <= item_s1.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (go_s1 && item_s1.last) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && item_s1.last) begin
			result_q.is_serial_device   <= (item_s1.device_class == usc_pkg::CLASS_CDC) ||
				(walk_next.control_seen && walk_next.data_seen) || known;
			result_q.cdc_control_found  <= walk_next.control_seen;
			result_q.cdc_data_found     <= walk_next.data_seen;
			result_q.known_id_match     <= known;
			result_q.walk_stopped_early <= walk_next.walk_stopped;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_stop_at_boundary: assert property (@(posedge clk) disable iff (!arst_n)
		walk_q.walk_stopped |-> (walk_q.bytes_left == 8'd0))
		else $error("walk stopped inside a descriptor");

	a_left_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(walk_q.bytes_left == 8'd0) || (walk_q.bytes_left < walk_q.current_length))
		else $error("bytes left not below descriptor length");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(go_s1 && item_s1.last) |=> ((byte_position_q == 16'd0) && (walk_q == '0)))
		else $error("walk state not cleared after last beat");

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(go_s1 && item_s1.last))
		else $error("result without a last beat");

	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && item_s1.last && result_valid_q))
		else $error("input stalled with no blocked last beat");

endmodule

FILE: sim/tb_usb_serial_device_classifier_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_usb_serial_device_classifier_core: descriptor walk and verdict test
// Streams configuration descriptor sets, one byte per beat, into the
// classifier. The sets are short hand-built cases, well-formed random sets,
// damaged sets, noise and one long set with a two-byte total. A scoreboard
// class predicts each verdict and checks every result beat field by field.
// Random idling runs on both channels, with a long result hold-off in the middle.
// ----------------------------------------------------------------------------
module tb_usb_serial_device_classifier_core;

	localparam logic [7:0] CFG_DESC_TYPE      = 8'h02;
	localparam logic [7:0] ENDPOINT_DESC_TYPE = 8'h05;
	localparam logic [7:0] CS_INTERFACE_TYPE  = 8'h24;
	localparam int         CYCLE_LIMIT        = 1000000;
	localparam int         HOLD_CYCLES        = 400;

	class serial_verdict_board;
		usc_pkg::usc_result_t verdicts_due[$];
		int          errors        = 0;
		int          bytes_taken   = 0;
		int          verdicts_seen = 0;
		int          serial_seen   = 0;
		int          stopped_seen  = 0;
		logic [15:0] pos, total;
		logic [7:0]  left, cur_len, cur_type, if_class;
		logic        ctl, dat, stopped;
		logic [7:0]  hdr [4];

		function new();
			wipe();
		endfunction

		function void wipe();
			pos      = '0;
			total    = '0;
			left     = '0;
			cur_len  = '0;
			cur_type = '0;
			if_class = '0;
			ctl      = 1'b0;
			dat      = 1'b0;
			stopped  = 1'b0;
			for (int i = 0; i < 4; i++) hdr[i] = '0;
		endfunction

		function void walk_step(logic [15:0] where, logic [7:0] b);
			logic [7:0] off;
			logic       is_if;
			if (stopped || where >= total) return;
			if (left == 8'd0) begin
				// too little room for a descriptor: quiet end of walk
				if (({1'b0, where} + 17'd2) > {1'b0, total}) return;
				if ((b < usc_pkg::MIN_DESC_LENGTH) ||
					(({1'b0, where} + {9'd0, b}) > {1'b0, total})) begin
					stopped = 1'b1;
					return;
				end
				cur_len  = b;
				left     = b - 8'd1;
				cur_type = '0;
				if_class = '0;
				return;
			end
			off   = cur_len - left;
			is_if = (cur_type == usc_pkg::DESC_TYPE_INTERFACE) &&
				(cur_len >= usc_pkg::IFACE_MIN_LENGTH);
			left  = left - 8'd1;
			case (off)
				usc_pkg::OFFSET_TYPE: cur_type = b;
				usc_pkg::OFFSET_CLASS: begin
					if_class = b;
					if (is_if && b == usc_pkg::CLASS_CDC_DATA) dat = 1'b1;
				end
				usc_pkg::OFFSET_SUBCLASS: begin
					if (is_if && if_class == usc_pkg::CLASS_CDC &&
						b == usc_pkg::SUBCLASS_ACM) ctl = 1'b1;
				end
				default: ;
			endcase
		endfunction

		function logic adapter_listed(logic [15:0] vid, logic [15:0] pid);
			case (vid)
				usc_pkg::VID_A, usc_pkg::VID_B: return 1'b1;
				usc_pkg::VID_C: return (pid == usc_pkg::PID_C0) ||
					(pid == usc_pkg::PID_C1) || (pid == usc_pkg::PID_C2);
				usc_pkg::VID_D: return pid == usc_pkg::PID_D;
				usc_pkg::VID_E: return pid == usc_pkg::PID_E;
				default:        return 1'b0;
			endcase
		endfunction

		function void take_byte(usc_pkg::usc_item_t it);
			usc_pkg::usc_result_t v;
			bytes_taken++;
			if (pos <= usc_pkg::HDR_LAST) begin
				hdr[pos[1:0]] = it.data_byte;
				// walk the buffered header once the total is known
				if (pos == usc_pkg::HDR_LAST || it.last) begin
					total = {hdr[3], hdr[2]};
					for (int i = 0; i <= int'(pos); i++) walk_step(16'(i), hdr[i]);
				end
			end else begin
				walk_step(pos, it.data_byte);
			end
			if (pos != usc_pkg::POS_MAX) pos = pos + 16'd1;
			if (it.last) begin
				v.known_id_match     = adapter_listed(it.vendor_id, it.product_id);
				v.cdc_control_found  = ctl;
				v.cdc_data_found     = dat;
				v.walk_stopped_early = stopped;
				v.is_serial_device   = (it.device_class == usc_pkg::CLASS_CDC) ||
					(ctl && dat) || v.known_id_match;
				verdicts_due.push_back(v);
				wipe();
			end
		endfunction

		function int field_diff(string name, logic want, logic got);
			if (got === want) return 0;
			$error("%s: expected %b, got %b", name, want, got);
			return 1;
		endfunction

		function void match_verdict(usc_pkg::usc_result_t got);
			usc_pkg::usc_result_t want;
			verdicts_seen++;
			if (verdicts_due.size() == 0) begin
				$error("result beat %b with no verdict pending", got);
				errors++;
				return;
			end
			want = verdicts_due.pop_front();
			if (want.is_serial_device) serial_seen++;
			if (want.walk_stopped_early) stopped_seen++;
			errors += field_diff("is_serial_device", want.is_serial_device,
				got.is_serial_device);
			errors += field_diff("cdc_control_found", want.cdc_control_found,
				got.cdc_control_found);
			errors += field_diff("cdc_data_found", want.cdc_data_found, got.cdc_data_found);
			errors += field_diff("known_id_match", want.known_id_match, got.known_id_match);
			errors += field_diff("walk_stopped_early", want.walk_stopped_early,
				got.walk_stopped_early);
		endfunction

		function int pending();
			return verdicts_due.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 item_valid;
	logic                 item_stall;
	usc_pkg::usc_item_t   item;
	logic                 result_valid;
	logic                 result_stall;
	usc_pkg::usc_result_t result;

	serial_verdict_board book = new();

	logic [7:0] set_q [$];
	int         starts_q [$];
	int         cycles       = 0;
	int         random_beats = 0;
	bit         gaps_on      = 1'b0;
	bit         rx_idle      = 1'b0;
	bit         hold_req     = 1'b0;

	usb_serial_device_classifier_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result side: check accepted beats, then pick next cycle's stall
	initial begin
		int hold_left;
		int burst_left;
		hold_left    = 0;
		burst_left   = 0;
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall) book.match_verdict(result);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (burst_left > 0) begin
				burst_left--;
				result_stall <= 1'b1;
			end else if (rx_idle && $urandom_range(0, 9) == 0) begin
				burst_left = $urandom_range(1, 15) - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	task automatic send_beat(input usc_pkg::usc_item_t it);
		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		book.take_byte(it);
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		do @(posedge clk); while (book.pending() != 0);
	endtask

	task automatic send_set(input logic [7:0] cls, input logic [15:0] vid,
		input logic [15:0] pid);
		usc_pkg::usc_item_t it;
		bit                 quiet;
		quiet = $urandom_range(0, 3) == 0;
		for (int i = 0; i < set_q.size(); i++) begin
			it.data_byte    = set_q[i];
			it.last         = (i == set_q.size() - 1);
			it.device_class = it.last ? cls : 8'($urandom);
			it.vendor_id    = it.last ? vid : 16'($urandom);
			it.product_id   = it.last ? pid : 16'($urandom);
			if (gaps_on && !quiet && $urandom_range(0, 5) == 0) begin
				item_valid <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			send_beat(it);
		end
	endtask

	function automatic void put_desc(int len, logic [7:0] typ);
		logic [7:0] cls, sub;
		case ($urandom_range(0, 2))
			0:       cls = usc_pkg::CLASS_CDC;
			1:       cls = usc_pkg::CLASS_CDC_DATA;
			default: cls = 8'($urandom);
		endcase
		sub = $urandom_range(0, 1) ? usc_pkg::SUBCLASS_ACM : 8'($urandom);
		starts_q.push_back(set_q.size());
		for (int k = 0; k < len; k++) begin
			case (k)
				0:       set_q.push_back(8'(len));
				1:       set_q.push_back(typ);
				5:       set_q.push_back(cls);
				6:       set_q.push_back(sub);
				default: set_q.push_back(8'($urandom));
			endcase
		end
	endfunction

	// configuration header, then descriptors that fill the total exactly
	function automatic void build_set(int total, int max_len);
		int         rem, len;
		logic [7:0] typ;
		set_q.delete();
		starts_q.delete();
		starts_q.push_back(0);
		set_q.push_back(8'd9);
		set_q.push_back(CFG_DESC_TYPE);
		set_q.push_back(total[7:0]);
		set_q.push_back(total[15:8]);
		repeat (5) set_q.push_back(8'($urandom));
		rem = total - 9;
		while (rem >= 2) begin
			case ($urandom_range(0, 5))
				0, 1: begin
					len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 12) : 9;
					typ = usc_pkg::DESC_TYPE_INTERFACE;
				end
				2: begin
					len = $urandom_range(2, 8);
					typ = usc_pkg::DESC_TYPE_INTERFACE;
				end
				3: begin
					len = 7;
					typ = ENDPOINT_DESC_TYPE;
				end
				4: begin
					len = 5;
					typ = CS_INTERFACE_TYPE;
				end
				default: begin
					len = $urandom_range(2, max_len);
					typ = 8'($urandom);
				end
			endcase
			if (len > rem) len = rem;
			put_desc(len, typ);
			rem -= len;
		end
		if (rem == 1) set_q.push_back(8'($urandom));
	endfunction

	function automatic void mangle_set();
		int k;
		case ($urandom_range(0, 4))
			0: set_q[$urandom_range(0, set_q.size() - 1)] = 8'($urandom);
			1: begin
				k = $urandom_range(1, set_q.size() - 1);
				while (set_q.size() > k) void'(set_q.pop_back());
			end
			2: repeat ($urandom_range(1, 10)) set_q.push_back(8'($urandom));
			3: begin
				set_q[2] = 8'($urandom);
				set_q[3] = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'h00;
			end
			default: begin
				// corrupt a length byte: too short or overrunning
				k = starts_q[$urandom_range(0, starts_q.size() - 1)];
				set_q[k] = $urandom_range(0, 1) ? 8'($urandom_range(0, 1)) :
					8'($urandom_range(100, 255));
			end
		endcase
	endfunction

	task automatic random_set();
		logic [7:0]  cls;
		logic [15:0] vid, pid;
		if ($urandom_range(0, 9) == 0) begin
			set_q.delete();
			repeat ($urandom_range(1, 40)) set_q.push_back(8'($urandom));
		end else begin
			build_set($urandom_range(9, 90), 40);
			if ($urandom_range(0, 9) < 3) mangle_set();
		end
		cls = $urandom_range(0, 5) == 0 ? usc_pkg::CLASS_CDC : 8'($urandom);
		pid = 16'($urandom);
		case ($urandom_range(0, 7))
			0: vid = usc_pkg::VID_A;
			1: vid = usc_pkg::VID_B;
			2: begin
				vid = usc_pkg::VID_C;
				case ($urandom_range(0, 3))
					0: pid = usc_pkg::PID_C0;
					1: pid = usc_pkg::PID_C1;
					2: pid = usc_pkg::PID_C2;
					default: ;
				endcase
			end
			3: begin
				vid = usc_pkg::VID_D;
				if ($urandom_range(0, 1)) pid = usc_pkg::PID_D;
			end
			4: begin
				vid = usc_pkg::VID_E;
				pid = $urandom_range(0, 1) ? usc_pkg::PID_E : usc_pkg::PID_E + 16'd1;
			end
			default: vid = 16'($urandom);
		endcase
		random_beats += set_q.size();
		send_set(cls, vid, pid);
	endtask

	initial begin
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// one byte only: header bytes missing, nothing walked
		set_q = '{8'hff};
		send_set(8'hff, usc_pkg::VID_A, 16'hffff);
		// zero length at the first descriptor
		set_q = '{8'h00, 8'h00, 8'h05};
		send_set(8'h00, 16'h0000, 16'h0000);
		// second descriptor overruns the total
		set_q = '{8'h02, 8'h00, 8'h04, 8'h00};
		send_set(usc_pkg::CLASS_CDC, 16'hffff, 16'h0000);
		// one byte left before the total: quiet end
		set_q = '{8'h04, CFG_DESC_TYPE, 8'h05, 8'h00, 8'h7e};
		send_set(8'h00, usc_pkg::VID_C, usc_pkg::PID_C2);
		// CDC data interface, then a byte past the total
		set_q = '{8'h04, CFG_DESC_TYPE, 8'd13, 8'h00, 8'd9, usc_pkg::DESC_TYPE_INTERFACE,
			8'h00, 8'h00, 8'h00, usc_pkg::CLASS_CDC_DATA, 8'h00, 8'h00, 8'h00, 8'haa};
		send_set(8'h00, usc_pkg::VID_E, usc_pkg::PID_E + 16'd1);
		wait_drained();

		gaps_on = 1'b1;
		rx_idle = 1'b1;
		while (random_beats < 500) random_set();

		// hold the result side while short sets keep coming
		wait_drained();
		hold_req = 1'b1;
		repeat (40) begin
			set_q.delete();
			repeat ($urandom_range(1, 3)) set_q.push_back(8'($urandom));
			random_beats += set_q.size();
			send_set(8'($urandom), 16'($urandom), 16'($urandom));
		end
		wait_drained();

		while (random_beats < 800) random_set();

		// last stretch: no idling on either side
		gaps_on = 1'b0;
		rx_idle = 1'b0;
		build_set(300, 255);
		random_beats += set_q.size();
		send_set(8'($urandom), 16'($urandom), 16'($urandom));
		while (random_beats < 1000 || book.verdicts_seen < 60) random_set();

		wait_drained();
		repeat (10) @(posedge clk);

		$display("%0d beats in, %0d verdicts checked (%0d serial, %0d walks stopped early)",
			book.bytes_taken, book.verdicts_seen, book.serial_seen, book.stopped_seen);
		$display("sets: short/malformed by hand, random and damaged, back-pressure, long set");
		if (book.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hdl/usc_pkg.sv
hdl/usc_walk.sv
hdl/usb_serial_device_classifier_core.sv
sim/tb_usb_serial_device_classifier_core.sv
